// ===== hw/rtl/mxstk_pkg.sv =====
package mxstk_pkg;

  localparam int DATA_W      = 32;
  localparam int REQ_W       = 2;
  localparam int FILL_W      = 9;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 112;
  localparam int DEPTH_DEF   = 256;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [REQ_W-1:0]         req_t;
  typedef logic [STAT_W-1:0]        stat_t;

  localparam req_t REQ_PUSH   = 2'd0;
  localparam req_t REQ_POP    = 2'd1;
  localparam req_t REQ_POPMAX = 2'd2;
  localparam req_t REQ_QUERY  = 2'd3;

  localparam stat_t ST_OK    = 2'd0;
  localparam stat_t ST_UNDER = 2'd1;
  localparam stat_t ST_OVER  = 2'd2;

  typedef logic [2:0] cell_op_t;

  localparam cell_op_t OP_HOLD   = 3'd0;
  localparam cell_op_t OP_PUSH   = 3'd1;
  localparam cell_op_t OP_POP    = 3'd2;
  localparam cell_op_t OP_FLAG   = 3'd3;
  localparam cell_op_t OP_REMOVE = 3'd4;
  localparam cell_op_t OP_MAX    = 3'd5;

  // Broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    cell_op_t op;
    word_t    gmax;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/mxstk_cell.sv =====
module mxstk_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  mxstk_pkg::cell_cmd_t cmd,
  input  mxstk_pkg::word_t   up_val,
  input  mxstk_pkg::word_t   up_mx,
  input  logic               up_vld,
  input  logic               up_flag,
  input  logic               up_match,
  input  mxstk_pkg::word_t   dn_val,
  input  mxstk_pkg::word_t   dn_mx,
  input  logic               dn_vld,
  output mxstk_pkg::word_t   val,
  output mxstk_pkg::word_t   mx,
  output logic               vld,
  output logic               flag,
  output logic               match
);

  mxstk_pkg::word_t val_r, val_nxt;
  mxstk_pkg::word_t mx_r, mx_nxt;
  logic             vld_r, vld_nxt;
  logic             flag_r, flag_nxt;
  logic             match_w;

  // This cell holds a copy of the current maximum.
  assign match_w = vld_r && (val_r == cmd.gmax);

  always_comb begin
    val_nxt  = val_r;
    mx_nxt   = mx_r;
    vld_nxt  = vld_r;
    flag_nxt = flag_r;
    unique case (cmd.op)
      mxstk_pkg::OP_HOLD: begin
      end
      mxstk_pkg::OP_PUSH: begin
        val_nxt = up_val;
        mx_nxt  = up_mx;
        vld_nxt = up_vld;
      end
      mxstk_pkg::OP_POP: begin
        val_nxt = dn_val;
        mx_nxt  = dn_mx;
        vld_nxt = dn_vld;
      end
      mxstk_pkg::OP_FLAG: begin
        // Set once some cell nearer the top holds the maximum.
        flag_nxt = up_flag || up_match;
      end
      mxstk_pkg::OP_REMOVE: begin
        // The topmost copy and every cell below it close the gap.
        if (flag_r || match_w) begin
          val_nxt = dn_val;
          mx_nxt  = dn_mx;
          vld_nxt = dn_vld;
        end
      end
      mxstk_pkg::OP_MAX: begin
        if (dn_vld && (dn_mx > val_r)) begin
          mx_nxt = dn_mx;
        end else begin
          mx_nxt = val_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    mx_r   <= mx_nxt;
    flag_r <= flag_nxt;
  end

  assign val   = val_r;
  assign mx    = mx_r;
  assign vld   = vld_r;
  assign flag  = flag_r;
  assign match = match_w;

endmodule

// ===== hw/rtl/max_stack_with_pop_max_top.sv =====
// Bounded stack of signed 32-bit values with push, pop, pop-max and query.
// Input channel: in_tuser carries the request kind, in_tdata the push value.
// Output channel: one transaction per request with the removed value, the
// new top, the current maximum and the fill level in out_tdata, and the
// status code (ok, underflow, overflow) in out_tuser.
// The stack lives in a chain of DEPTH cells with the top always in the
// first cell; each cell also keeps the maximum of itself and all cells
// below it, so top and maximum are read from the first cell.
// Push, pop and query go from the idle state through a report state into
// the output register; a new request is taken only in the idle state.
// Pop-max for a stack of N entries walks a flag down the chain in one pass
// to find the topmost maximum, closes the gap in a remove step, and then
// rebuilds the running maxima from the bottom up in a second pass.
// Reset empties the stack. While a result waits on a stalled receiver the
// next request is still taken and executed; its result is held until the
// output register frees up.
module max_stack_with_pop_max_top #(
  parameter int DEPTH = mxstk_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // push_value
  input  logic [mxstk_pkg::IN_TDATA_W-1:0]    in_tdata,
  // req_type
  input  logic [mxstk_pkg::REQ_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // removed_value, top_value, max_value, fill_level, zero fill
  output logic [mxstk_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // status
  output logic [mxstk_pkg::STAT_W-1:0]        out_tuser
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PAD_W = mxstk_pkg::OUT_TDATA_W - 3 * mxstk_pkg::DATA_W - mxstk_pkg::FILL_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FLAG   = 3'd1;
  localparam logic [2:0] S_REMOVE = 3'd2;
  localparam logic [2:0] S_MAX    = 3'd3;
  localparam logic [2:0] S_REPORT = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   sweep_r, sweep_nxt;
  mxstk_pkg::word_t  removed_r, removed_nxt;
  mxstk_pkg::stat_t  status_r, status_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic [mxstk_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  mxstk_pkg::stat_t  out_stat_r, out_stat_nxt;

  mxstk_pkg::cell_cmd_t cmd;
  mxstk_pkg::word_t  push_val;
  mxstk_pkg::word_t  push_mx;
  mxstk_pkg::word_t  top_w;
  mxstk_pkg::word_t  max_w;
  logic              in_acc;
  logic              out_free;

  mxstk_pkg::word_t val_w [DEPTH];
  mxstk_pkg::word_t mx_w  [DEPTH];
  logic             vld_w   [DEPTH];
  logic             flag_w  [DEPTH];
  logic             match_w [DEPTH];

  assign push_val = mxstk_pkg::word_t'(in_tdata[mxstk_pkg::DATA_W-1:0]);
  assign push_mx  = (vld_w[0] && (mx_w[0] > push_val)) ? mx_w[0] : push_val;
  assign top_w    = vld_w[0] ? val_w[0] : '0;
  assign max_w    = vld_w[0] ? mx_w[0] : '0;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      mxstk_pkg::word_t up_val, up_mx, dn_val, dn_mx;
      logic             up_vld, up_flag, up_match, dn_vld;

      if (g == 0) begin : g_first
        assign up_val   = push_val;
        assign up_mx    = push_mx;
        assign up_vld   = 1'b1;
        assign up_flag  = 1'b0;
        assign up_match = 1'b0;
      end else begin : g_mid
        assign up_val   = val_w[g-1];
        assign up_mx    = mx_w[g-1];
        assign up_vld   = vld_w[g-1];
        assign up_flag  = flag_w[g-1];
        assign up_match = match_w[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
        assign dn_val = '0;
        assign dn_mx  = '0;
        assign dn_vld = 1'b0;
      end else begin : g_inner
        assign dn_val = val_w[g+1];
        assign dn_mx  = mx_w[g+1];
        assign dn_vld = vld_w[g+1];
      end

      mxstk_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .up_val   (up_val),
        .up_mx    (up_mx),
        .up_vld   (up_vld),
        .up_flag  (up_flag),
        .up_match (up_match),
        .dn_val   (dn_val),
        .dn_mx    (dn_mx),
        .dn_vld   (dn_vld),
        .val      (val_w[g]),
        .mx       (mx_w[g]),
        .vld      (vld_w[g]),
        .flag     (flag_w[g]),
        .match    (match_w[g])
      );
    end
  endgenerate

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    sweep_nxt    = sweep_r;
    removed_nxt  = removed_r;
    status_nxt   = status_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    out_stat_nxt = out_stat_r;
    cmd.op       = mxstk_pkg::OP_HOLD;
    cmd.gmax     = mx_w[0];

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          removed_nxt = '0;
          status_nxt  = mxstk_pkg::ST_OK;
          state_nxt   = S_REPORT;
          case (in_tuser)
            mxstk_pkg::REQ_PUSH: begin
              if (count_r == CW'(DEPTH)) begin
                status_nxt = mxstk_pkg::ST_OVER;
              end else begin
                cmd.op    = mxstk_pkg::OP_PUSH;
                count_nxt = count_r + 1'b1;
              end
            end
            mxstk_pkg::REQ_POP: begin
              if (count_r == '0) begin
                status_nxt = mxstk_pkg::ST_UNDER;
              end else begin
                cmd.op      = mxstk_pkg::OP_POP;
                removed_nxt = val_w[0];
                count_nxt   = count_r - 1'b1;
              end
            end
            mxstk_pkg::REQ_POPMAX: begin
              if (count_r == '0) begin
                status_nxt = mxstk_pkg::ST_UNDER;
              end else begin
                removed_nxt = mx_w[0];
                sweep_nxt   = count_r;
                state_nxt   = S_FLAG;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FLAG: begin
        cmd.op    = mxstk_pkg::OP_FLAG;
        sweep_nxt = sweep_r - 1'b1;
        if (sweep_r == CW'(1)) begin
          state_nxt = S_REMOVE;
        end
      end
      S_REMOVE: begin
        cmd.op    = mxstk_pkg::OP_REMOVE;
        count_nxt = count_r - 1'b1;
        sweep_nxt = count_r - 1'b1;
        if (count_r == CW'(1)) begin
          state_nxt = S_REPORT;
        end else begin
          state_nxt = S_MAX;
        end
      end
      S_MAX: begin
        cmd.op    = mxstk_pkg::OP_MAX;
        sweep_nxt = sweep_r - 1'b1;
        if (sweep_r == CW'(1)) begin
          state_nxt = S_REPORT;
        end
      end
      S_REPORT: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {{PAD_W{1'b0}}, mxstk_pkg::FILL_W'(count_r),
                          max_w, top_w, removed_r};
          out_stat_nxt = status_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      sweep_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      sweep_r   <= sweep_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    removed_r  <= removed_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule
